[rtl/core/vpp_pkg.sv]
// Shared types, constants and helpers for the voxel point projector.
// No dependencies; used by rtl/core/voxel_point_projector.sv.
package vpp_pkg;

	// Screen geometry
	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 1024;
	localparam logic signed [63:0] SCR_W_S = 64'(SCREEN_WIDTH);
	localparam logic signed [63:0] SCR_H_S = 64'(SCREEN_HEIGHT);
	localparam logic signed [63:0] SCR_AREA_S = 64'(SCREEN_WIDTH) * 64'(SCREEN_HEIGHT);

	// 0.06 in Q0.16
	localparam logic signed [13:0] PAR_SCALE = 14'sd3932;
	localparam logic [2:0] GRAY_INDEX = 3'd1;

	// Quotient bits of the perspective divider (an overflow forces magnitude 2^34)
	localparam int DIV_QBITS = 35;
	localparam int DIV_DBITS = 34;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Configuration register indexes
	typedef enum logic [3:0] {
		REG_X_COEFFS    = 4'd0,
		REG_Y_COEFFS    = 4'd1,
		REG_Z_COEFFS    = 4'd2,
		REG_TRANSLATION = 4'd3,
		REG_CENTER      = 4'd4,
		REG_WINDOW      = 4'd5,
		REG_VIEWPORT    = 4'd6,
		REG_DEPTH_MODES = 4'd7
	} cfg_reg_t;

	// One coordinate lane in the divider chain
	typedef struct packed {
		logic [DIV_DBITS-1:0]  rem;
		logic [DIV_QBITS-1:0]  nlow;
		logic [DIV_QBITS-1:0]  quo;
		logic                  ovf;
		logic                  neg;
		logic                  use_alt;
		logic signed [31:0]    alt;
	} div_lane_t;

	// One divider stage: both lanes share the divisor
	typedef struct packed {
		logic                  vld;
		logic [2:0]            color;
		logic [DIV_DBITS-1:0]  dvs;
		div_lane_t             lx;
		div_lane_t             ly;
	} div_stage_t;

	// Saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sd2147483647) begin
			r = S32_MAX;
		end else if (v < -40'sd2147483648) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// One restoring division step: one quotient bit
	function automatic div_lane_t div_step(input div_lane_t l, input logic [DIV_DBITS-1:0] d);
		div_lane_t o;
		logic [DIV_DBITS:0] t;
		logic [DIV_DBITS:0] diff;
		logic ge;
		o    = l;
		t    = {l.rem, l.nlow[DIV_QBITS-1]};
		diff = t - {1'b0, d};
		ge   = (t >= {1'b0, d});
		o.rem  = ge ? diff[DIV_DBITS-1:0] : t[DIV_DBITS-1:0];
		o.nlow = {l.nlow[DIV_QBITS-2:0], 1'b0};
		o.quo  = {l.quo[DIV_QBITS-2:0], ge};
		return o;
	endfunction

endpackage

[rtl/core/voxel_point_projector.sv]
// Voxel point projector: rotation, depth clip, parallel/perspective projection,
// window clip, viewport map and framebuffer index. Depends on rtl/core/vpp_pkg.sv.
// 5 front stages, 35 divider stages (one quotient bit each), 4 back stages.
// Throughput: one voxel per cycle; the whole pipe advances whenever the
// output register is empty or its transfer completes.
// Reset clears all valid bits and loads the configuration reset values.
module voxel_point_projector (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream: point_x[31:0], point_y[63:32], point_z[95:64], color_index[98:96]
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,
	// master stream: pixel_index[19:0], pixel_color[22:20], only_if_empty[23]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [3:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int NQ = vpp_pkg::DIV_QBITS;
	localparam int ND = vpp_pkg::DIV_DBITS;

	// Configuration registers
	logic [47:0] x_coeffs_q, y_coeffs_q, z_coeffs_q;
	logic [62:0] translation_q, center_q;
	logic [63:0] window_q, viewport_q, modes_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_coeffs_q    <= 48'd16384;
			y_coeffs_q    <= 48'd1 << 30;
			z_coeffs_q    <= 48'd1 << 46;
			translation_q <= '0;
			center_q      <= '0;
			window_q      <= '0;
			viewport_q    <= '0;
			modes_q       <= 64'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (vpp_pkg::cfg_reg_t'(cfg_index))
				vpp_pkg::REG_X_COEFFS:    x_coeffs_q    <= cfg_data[47:0];
				vpp_pkg::REG_Y_COEFFS:    y_coeffs_q    <= cfg_data[47:0];
				vpp_pkg::REG_Z_COEFFS:    z_coeffs_q    <= cfg_data[47:0];
				vpp_pkg::REG_TRANSLATION: translation_q <= cfg_data[62:0];
				vpp_pkg::REG_CENTER:      center_q      <= cfg_data[62:0];
				vpp_pkg::REG_WINDOW:      window_q      <= cfg_data;
				vpp_pkg::REG_VIEWPORT:    viewport_q    <= cfg_data;
				vpp_pkg::REG_DEPTH_MODES: modes_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Configuration fields
	logic signed [15:0] coef [3][3];
	logic signed [20:0] trn [3];
	logic signed [20:0] cx, cy, cz;
	logic signed [30:0] front, back;
	logic signed [15:0] wxl, wxh, wyl, wyh;
	logic signed [16:0] offs_x, offs_y, scl_x, scl_y;
	logic               clip_on, par_mode;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			coef[0][c] = x_coeffs_q[16*c +: 16];
			coef[1][c] = y_coeffs_q[16*c +: 16];
			coef[2][c] = z_coeffs_q[16*c +: 16];
			trn[c]     = translation_q[21*c +: 21];
		end
	end

	assign cx       = center_q[20:0];
	assign cy       = center_q[41:21];
	assign cz       = center_q[62:42];
	assign clip_on  = modes_q[0];
	assign par_mode = modes_q[1];
	assign front    = modes_q[32:2];
	assign back     = modes_q[63:33];
	assign wxl      = window_q[15:0];
	assign wxh      = window_q[31:16];
	assign wyl      = window_q[47:32];
	assign wyh      = window_q[63:48];
	assign offs_x   = {1'b0, viewport_q[15:0]};
	assign offs_y   = {1'b0, viewport_q[31:16]};
	assign scl_x    = {1'b0, viewport_q[47:32]};
	assign scl_y    = {1'b0, viewport_q[63:48]};

	// Global advance: the pipe moves when the output slot frees up
	logic en;
	logic vld_s9;
	assign en       = !vld_s9 || m_tready;
	assign s_tready = en;

	logic signed [31:0] pt [3];
	assign pt[0] = s_tdata[31:0];
	assign pt[1] = s_tdata[63:32];
	assign pt[2] = s_tdata[95:64];

	// Stage 1: rotation products
	logic               vld_s1;
	logic [2:0]         color_s1;
	logic signed [47:0] prod_s1 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s1 <= s_tdata[98:96];
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= coef[r][c] * pt[c];
				end
			end
		end
	end

	// Stage 2: row sums, translation, rounding shift, saturation
	logic               vld_s2;
	logic [2:0]         color_s2;
	logic signed [31:0] view_s2 [3];
	logic signed [50:0] acc [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 51'(prod_s1[r][0]) + 51'(prod_s1[r][1]) + 51'(prod_s1[r][2])
				+ (51'(trn[r]) <<< 26) + 51'sd8192;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s2 <= color_s1;
			for (int r = 0; r < 3; r++) begin
				view_s2[r] <= vpp_pkg::sat32(40'(acc[r] >>> 14));
			end
		end
	end

	// Stage 3: depth clip, offsets from the projection center, divisor
	logic               vld_s3;
	logic [2:0]         color_s3;
	logic signed [33:0] dx_s3, dy_s3, den_s3;
	logic signed [44:0] vz45, fr45, bk45;
	logic               clip;

	assign vz45 = 45'(view_s2[2]);
	assign fr45 = 45'(front) <<< 12;
	assign bk45 = 45'(back) <<< 12;
	assign clip = clip_on && (((vz45 + fr45) > 45'sd0) || ((vz45 + bk45) < 45'sd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2 && !clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s3 <= color_s2;
			dx_s3    <= 34'(view_s2[0]) - (34'(cx) <<< 12);
			dy_s3    <= 34'(view_s2[1]) - (34'(cy) <<< 12);
			den_s3   <= (34'(cz) <<< 12) - 34'(view_s2[2]);
		end
	end

	// Stage 4: numerators, parallel results, divisor magnitude
	logic               vld_s4;
	logic [2:0]         color_s4;
	logic signed [54:0] num_x_s4, num_y_s4;
	logic signed [31:0] alt_x_s4, alt_y_s4;
	logic               use_alt_s4, den_neg_s4;
	logic [ND-1:0]      dvs_s4;
	logic signed [47:0] par_x, par_y;
	logic signed [31:0] zval_x, zval_y;
	logic               den_zero;

	assign par_x    = 48'(dx_s3) * 48'(vpp_pkg::PAR_SCALE) + 48'sd32768;
	assign par_y    = 48'(dy_s3) * 48'(vpp_pkg::PAR_SCALE) + 48'sd32768;
	assign den_zero = (den_s3 == 34'sd0);
	assign zval_x   = (dx_s3 > 34'sd0) ? vpp_pkg::S32_MAX :
		((dx_s3 < 34'sd0) ? vpp_pkg::S32_MIN : 32'sd0);
	assign zval_y   = (dy_s3 > 34'sd0) ? vpp_pkg::S32_MAX :
		((dy_s3 < 34'sd0) ? vpp_pkg::S32_MIN : 32'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s4   <= color_s3;
			num_x_s4   <= dx_s3 * cz;
			num_y_s4   <= dy_s3 * cz;
			use_alt_s4 <= par_mode || den_zero;
			alt_x_s4   <= par_mode ? 32'(par_x >>> 16) : zval_x;
			alt_y_s4   <= par_mode ? 32'(par_y >>> 16) : zval_y;
			den_neg_s4 <= den_s3[33];
			dvs_s4     <= den_s3[33] ? ND'(-den_s3) : ND'(den_s3);
		end
	end

	// Stage 5 and the divider chain: |num| * 4096 / |den|, one bit per stage
	vpp_pkg::div_stage_t div_s5 [0:NQ];
	vpp_pkg::div_stage_t div_init;
	logic [54:0] abs_x, abs_y;
	logic [65:0] nx, ny;

	assign abs_x = num_x_s4[54] ? 55'(-num_x_s4) : 55'(num_x_s4);
	assign abs_y = num_y_s4[54] ? 55'(-num_y_s4) : 55'(num_y_s4);
	assign nx    = {abs_x[53:0], 12'd0};
	assign ny    = {abs_y[53:0], 12'd0};

	always_comb begin
		div_init.vld        = vld_s4;
		div_init.color      = color_s4;
		div_init.dvs        = dvs_s4;
		div_init.lx.rem     = ND'(nx[65:NQ]);
		div_init.lx.nlow    = nx[NQ-1:0];
		div_init.lx.quo     = '0;
		div_init.lx.ovf     = (ND'(nx[65:NQ]) >= dvs_s4);
		div_init.lx.neg     = num_x_s4[54] ^ den_neg_s4;
		div_init.lx.use_alt = use_alt_s4;
		div_init.lx.alt     = alt_x_s4;
		div_init.ly.rem     = ND'(ny[65:NQ]);
		div_init.ly.nlow    = ny[NQ-1:0];
		div_init.ly.quo     = '0;
		div_init.ly.ovf     = (ND'(ny[65:NQ]) >= dvs_s4);
		div_init.ly.neg     = num_y_s4[54] ^ den_neg_s4;
		div_init.ly.use_alt = use_alt_s4;
		div_init.ly.alt     = alt_y_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NQ; k++) begin
				div_s5[k] <= '0;
			end
		end else if (en) begin
			div_s5[0] <= div_init;
			for (int k = 1; k <= NQ; k++) begin
				div_s5[k].vld   <= div_s5[k-1].vld;
				div_s5[k].color <= div_s5[k-1].color;
				div_s5[k].dvs   <= div_s5[k-1].dvs;
				div_s5[k].lx    <= vpp_pkg::div_step(div_s5[k-1].lx, div_s5[k-1].dvs);
				div_s5[k].ly    <= vpp_pkg::div_step(div_s5[k-1].ly, div_s5[k-1].dvs);
			end
		end
	end

	// Stage 6: signed offset, add center, saturate, pick projection
	logic               vld_s6;
	logic [2:0]         color_s6;
	logic signed [31:0] px_s6, py_s6;
	logic [NQ-1:0]      mag_x, mag_y;
	logic signed [36:0] sum_x, sum_y;
	vpp_pkg::div_stage_t dlast;

	assign dlast = div_s5[NQ];
	assign mag_x = dlast.lx.ovf ? NQ'(1) << (NQ-1) : dlast.lx.quo;
	assign mag_y = dlast.ly.ovf ? NQ'(1) << (NQ-1) : dlast.ly.quo;
	assign sum_x = (37'(cx) <<< 12) + (dlast.lx.neg ? -$signed(37'(mag_x)) : $signed(37'(mag_x)));
	assign sum_y = (37'(cy) <<< 12) + (dlast.ly.neg ? -$signed(37'(mag_y)) : $signed(37'(mag_y)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dlast.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s6 <= dlast.color;
			px_s6    <= dlast.lx.use_alt ? dlast.lx.alt : vpp_pkg::sat32(40'(sum_x));
			py_s6    <= dlast.ly.use_alt ? dlast.ly.alt : vpp_pkg::sat32(40'(sum_y));
		end
	end

	// Stage 7: window clip and viewport scale
	logic               vld_s7;
	logic [2:0]         color_s7;
	logic signed [49:0] sprod_x_s7, sprod_y_s7;
	logic signed [32:0] px33, py33, xlo, xhi, ylo, yhi;
	logic               in_win;

	assign px33   = 33'(px_s6);
	assign py33   = 33'(py_s6);
	assign xlo    = 33'(wxl) <<< 8;
	assign xhi    = 33'(wxh) <<< 8;
	assign ylo    = 33'(wyl) <<< 8;
	assign yhi    = 33'(wyh) <<< 8;
	assign in_win = (px33 >= xlo) && (px33 <= xhi) && (py33 >= ylo) && (py33 <= yhi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6 && in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s7   <= color_s6;
			sprod_x_s7 <= (px33 - xlo) * scl_x;
			sprod_y_s7 <= (py33 - ylo) * scl_y;
		end
	end

	// Stage 8: viewport offset, screen size, rounding
	logic               vld_s8;
	logic [2:0]         color_s8;
	logic signed [37:0] xi_s8, yi_s8;
	logic signed [63:0] uw_x, uw_y;

	assign uw_x = 64'(50'sd0 + sprod_x_s7 + (50'(offs_x) <<< 12)) * vpp_pkg::SCR_W_S;
	assign uw_y = 64'(50'sd0 + sprod_y_s7 + (50'(offs_y) <<< 12)) * vpp_pkg::SCR_H_S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s8 <= color_s7;
			xi_s8    <= 38'((uw_x + 64'sd33554432) >>> 26);
			yi_s8    <= 38'((uw_y + 64'sd33554432) >>> 26);
		end
	end

	// Stage 9: mirrored index, range check, output register
	logic [19:0]        index_s9;
	logic [2:0]         color_s9;
	logic signed [63:0] pos;
	logic               pos_ok;

	assign pos = vpp_pkg::SCR_W_S - 64'(xi_s8)
		+ (vpp_pkg::SCR_H_S - 64'sd1 - 64'(yi_s8)) * vpp_pkg::SCR_W_S;
	assign pos_ok = (pos > 64'sd0) && (pos < vpp_pkg::SCR_AREA_S);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8 && pos_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			index_s9 <= pos[19:0];
			color_s9 <= color_s8;
		end
	end

	assign m_tvalid = vld_s9;
	assign m_tdata  = {(color_s9 == vpp_pkg::GRAY_INDEX), color_s9, index_s9};

	// Divider keeps its partial remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(dlast.vld && !dlast.lx.ovf && dlast.dvs != '0) |-> (dlast.lx.rem < dlast.dvs))
		else $error("divider remainder out of range");

	// Index zero is never written
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:0] != 20'd0))
		else $error("pixel index zero delivered");

	// Gray flag follows the color
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23] == (m_tdata[22:20] == vpp_pkg::GRAY_INDEX)))
		else $error("only_if_empty mismatch");

	// A stall freezes the middle of the pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s4) && $stable(vld_s7)))
		else $error("pipeline moved during stall");

endmodule

[test/tb_voxel_point_projector.sv]
// Self-checking testbench for voxel_point_projector: a bit-exact projection
// predictor, directed and random voxels, several register settings and idling.
// Depends on rtl/core/vpp_pkg.sv and rtl/core/voxel_point_projector.sv.
module tb_voxel_point_projector;

	// Laid out as m_tdata, highest field first
	typedef struct packed {
		logic        empty_only;
		logic [2:0]  color;
		logic [19:0] index;
	} pixel_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [3:0]   cfg_index;
	logic [63:0]  cfg_data;

	// Predictor copy of the register file
	logic [63:0] r_xc, r_yc, r_zc, r_trans, r_center, r_window, r_view, r_depth;

	pixel_t pixel_queue[$];
	int     errors;
	int     gap_pct;
	int     stall_pct;
	int     hold_req;
	int     hold_cnt;

	voxel_point_projector dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 400000);
		$display("FAIL voxel_point_projector");
		$finish;
	end

	// Signed subfield of a register word
	function automatic longint sfield(input logic [63:0] w, input int pos, input int width);
		longint t;
		t = longint'(w << (64 - pos - width));
		return t >>> (64 - width);
	endfunction

	function automatic longint ufield(input logic [63:0] w, input int pos, input int width);
		return longint'((w >> pos) & ((64'd1 << width) - 64'd1));
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rotate(input logic [63:0] co, input longint px, input longint py,
			input longint pz, input longint t);
		longint acc;
		acc = px * sfield(co, 0, 16) + py * sfield(co, 16, 16) + pz * sfield(co, 32, 16)
			+ t * (64'sd1 <<< 26);
		return clamp32((acc + 64'sd8192) >>> 14);
	endfunction

	function automatic longint persp(input longint v, input longint c, input longint cz,
			input longint den);
		longint d, num, q, r, off;
		d = v - c * 4096;
		if (den == 0) return d > 0 ? 64'sd2147483647 : (d < 0 ? -64'sd2147483648 : 64'sd0);
		num = d * cz;
		q = num / den;
		r = num % den;
		if (q > (64'sd1 <<< 22)) off = 64'sd1 <<< 34;
		else if (q < -(64'sd1 <<< 22)) off = -(64'sd1 <<< 34);
		else off = q * 4096 + (r * 4096) / den;
		return clamp32(c * 4096 + off);
	endfunction

	function automatic longint to_screen(input longint p, input longint lo, input longint scale,
			input longint offs);
		longint u;
		u = (p - lo * 256) * scale + offs * 4096;
		return (u * 1024 + (64'sd1 <<< 25)) >>> 26;
	endfunction

	// Projects one voxel; returns 1 when it lands on a writable pixel
	function automatic bit project_voxel(input logic [103:0] d, output pixel_t pix);
		longint ptx, pty, ptz, vx, vy, vz, cx, cy, cz, front, back, px, py, den, xi, yi, pos;
		longint wxl, wxh, wyl, wyh;
		pix = '0;
		ptx = sfield(d[63:0], 0, 32);
		pty = sfield(d[63:0], 32, 32);
		ptz = sfield({32'd0, d[95:64]}, 0, 32);
		cx = sfield(r_center, 0, 21);
		cy = sfield(r_center, 21, 21);
		cz = sfield(r_center, 42, 21);
		front = sfield(r_depth, 2, 31);
		back = sfield(r_depth, 33, 31);
		wxl = sfield(r_window, 0, 16);
		wxh = sfield(r_window, 16, 16);
		wyl = sfield(r_window, 32, 16);
		wyh = sfield(r_window, 48, 16);
		vx = rotate(r_xc, ptx, pty, ptz, sfield(r_trans, 0, 21));
		vy = rotate(r_yc, ptx, pty, ptz, sfield(r_trans, 21, 21));
		vz = rotate(r_zc, ptx, pty, ptz, sfield(r_trans, 42, 21));
		if (r_depth[0] && (vz > -front * 4096 || vz < -back * 4096)) return 1'b0;
		if (r_depth[1]) begin
			px = ((vx - cx * 4096) * 3932 + 32768) >>> 16;
			py = ((vy - cy * 4096) * 3932 + 32768) >>> 16;
		end else begin
			den = cz * 4096 - vz;
			px = persp(vx, cx, cz, den);
			py = persp(vy, cy, cz, den);
		end
		if (px < wxl * 256 || px > wxh * 256 || py < wyl * 256 || py > wyh * 256) return 1'b0;
		xi = to_screen(px, wxl, ufield(r_view, 32, 16), ufield(r_view, 0, 16));
		yi = to_screen(py, wyl, ufield(r_view, 48, 16), ufield(r_view, 16, 16));
		pos = 1024 - xi + (1023 - yi) * 1024;
		if (pos <= 0 || pos >= 1024 * 1024) return 1'b0;
		pix.index = pos[19:0];
		pix.color = d[98:96];
		pix.empty_only = (d[98:96] == vpp_pkg::GRAY_INDEX);
		return 1'b1;
	endfunction

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pixel_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel transfer %h", $time, m_tdata);
			end else begin
				want = pixel_queue.pop_front();
				if (got.index !== want.index) begin
					errors++;
					$display("%0t: pixel_index expected %h got %h", $time, want.index, got.index);
				end
				if (got.color !== want.color) begin
					errors++;
					$display("%0t: pixel_color expected %h got %h", $time, want.color, got.color);
				end
				if (got.empty_only !== want.empty_only) begin
					errors++;
					$display("%0t: only_if_empty expected %b got %b", $time, want.empty_only,
						got.empty_only);
				end
			end
		end
	end

	task automatic write_reg(input vpp_pkg::cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			vpp_pkg::REG_X_COEFFS:    r_xc = val & 64'hffff_ffff_ffff;
			vpp_pkg::REG_Y_COEFFS:    r_yc = val & 64'hffff_ffff_ffff;
			vpp_pkg::REG_Z_COEFFS:    r_zc = val & 64'hffff_ffff_ffff;
			vpp_pkg::REG_TRANSLATION: r_trans = val & 64'h7fff_ffff_ffff_ffff;
			vpp_pkg::REG_CENTER:      r_center = val & 64'h7fff_ffff_ffff_ffff;
			vpp_pkg::REG_WINDOW:      r_window = val;
			vpp_pkg::REG_VIEWPORT:    r_view = val;
			vpp_pkg::REG_DEPTH_MODES: r_depth = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_voxel(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic [2:0] col);
		pixel_t pix;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, col, z, y, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (project_voxel({5'd0, col, z, y, x}, pix)) pixel_queue.push_back(pix);
		// Each following cycle stays idle with probability gap_pct
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop offering, drain all pixels, then let dropped voxels leave the pipe
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [62:0] pack21(input int a, input int b, input int c);
		return {c[20:0], b[20:0], a[20:0]};
	endfunction

	// Usable settings: window +-lim units, viewport roughly filling the screen
	task automatic load_scene(input bit parallel, input bit clip, input int cz);
		int lim;
		lim = $urandom_range(4, 10);
		write_reg(vpp_pkg::REG_X_COEFFS, 64'd16384);
		write_reg(vpp_pkg::REG_Y_COEFFS, 64'd16384 << 16);
		write_reg(vpp_pkg::REG_Z_COEFFS, 64'd16384 << 32);
		write_reg(vpp_pkg::REG_TRANSLATION, 64'd0);
		write_reg(vpp_pkg::REG_CENTER, {1'b0, pack21(0, 0, cz)});
		write_reg(vpp_pkg::REG_WINDOW,
			{16'(lim * 16), 16'(-lim * 16), 16'(lim * 16), 16'(-lim * 16)});
		write_reg(vpp_pkg::REG_VIEWPORT, {16'(8192 / lim), 16'(8192 / lim), 16'd0, 16'd0});
		write_reg(vpp_pkg::REG_DEPTH_MODES, {31'(200), 31'(-200), parallel, clip});
	endtask

	function automatic logic [31:0] rand_coord(input int span);
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2, 3, 4: return 32'($signed($urandom_range(0, 400 * 4096)) - 200 * 4096);
			default: return 32'($signed($urandom_range(0, 2 * span * 4096)) - span * 4096);
		endcase
	endfunction

	task automatic random_voxels(input int count, input int span);
		repeat (count) send_voxel(rand_coord(span), rand_coord(span), rand_coord(span),
			3'($urandom_range(0, 7)));
	endtask

	// Settings reached by the default registers: nothing lands on screen
	task automatic test_reset_settings;
		send_voxel(32'd0, 32'd0, 32'd0, 3'd1);
		send_voxel(32'h7fff_ffff, 32'h8000_0000, 32'd0, 3'd7);
		drain();
	endtask

	// Parallel mode: field extremes, every color, clipping on and off
	task automatic test_parallel;
		load_scene(1'b1, 1'b1, 0);
		for (int c = 0; c < 8; c++)
			send_voxel(32'(c * 40000 - 150000), 32'(c * 30000), 32'd0, 3'(c));
		send_voxel(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 3'd1);
		send_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd1);
		send_voxel(32'd0, 32'd0, 32'(201 * 4096), 3'd2);
		send_voxel(32'd0, 32'd0, 32'(-201 * 4096), 3'd3);
		drain();
		write_reg(vpp_pkg::REG_DEPTH_MODES, 64'd2);
		send_voxel(32'd4096, 32'd0, 32'h7fff_ffff, 3'd4);
		drain();
	endtask

	// Perspective: ordinary points, a zero divisor and a saturated quotient
	task automatic test_perspective;
		load_scene(1'b0, 1'b0, 100);
		send_voxel(32'(3 * 4096), 32'(-2 * 4096), 32'd0, 3'd5);
		send_voxel(32'(3 * 4096), 32'(-2 * 4096), 32'(50 * 4096), 3'd1);
		send_voxel(32'd4096, 32'd0, 32'(100 * 4096), 3'd6);
		send_voxel(32'd0, 32'd0, 32'(100 * 4096), 3'd1);
		send_voxel(32'(-4096), 32'd4096, 32'(100 * 4096), 3'd2);
		send_voxel(32'(500 * 4096), 32'd0, 32'(100 * 4096 - 1), 3'd0);
		send_voxel(32'd0, 32'd0, 32'(150 * 4096), 3'd1);
		drain();
	endtask

	// Register extremes and arbitrary words on every register
	task automatic test_register_extremes;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 8; i++)
				write_reg(vpp_pkg::cfg_reg_t'(i), k == 0 ? 64'hffff_ffff_ffff_ffff :
					(k == 1 ? 64'd0 : {$urandom, $urandom}));
			random_voxels(8, 12);
			drain();
		end
	endtask

	// Mixed settings under every idling mode
	task automatic test_random_scenes;
		int modes[4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{34, 34}};
		for (int ph = 0; ph < 8; ph++) begin
			gap_pct = modes[ph % 4][0];
			stall_pct = modes[ph % 4][1];
			load_scene(ph[0], ph[1], ph[2] ? $urandom_range(20, 300) : -$urandom_range(20, 300));
			if ($urandom_range(0, 1)) begin
				write_reg(vpp_pkg::REG_X_COEFFS, {16'($urandom), 16'($urandom_range(0, 4000)),
					16'($urandom_range(12000, 16384))});
				write_reg(vpp_pkg::REG_TRANSLATION, {1'b0, pack21($urandom_range(0, 4) - 2,
					$urandom_range(0, 4) - 2, $urandom_range(0, 6) - 3)});
			end
			random_voxels(135, ph[0] ? 160 : 12);
			drain();
		end
		gap_pct = 0;
		stall_pct = 0;
	endtask

	// Long output hold-off while input keeps coming: the pipe must stall
	task automatic test_backpressure;
		load_scene(1'b1, 1'b0, 0);
		hold_req = 300;
		random_voxels(120, 150);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = vpp_pkg::REG_X_COEFFS;
		cfg_data = '0;
		errors = 0;
		gap_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_cnt = 0;
		r_xc = 64'd16384;
		r_yc = 64'd16384 << 16;
		r_zc = 64'd16384 << 32;
		r_trans = '0;
		r_center = '0;
		r_window = '0;
		r_view = '0;
		r_depth = 64'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_parallel();
		test_perspective();
		test_register_extremes();
		test_random_scenes();
		test_backpressure();
		if (errors == 0) begin
			$display("PASS voxel_point_projector");
		end else begin
			$display("FAIL voxel_point_projector");
		end
		$finish;
	end

endmodule
